// ===== hw/rtl/crm_pkg.sv =====
// ----------------------------------------------------------------------------
// crm_pkg
// Shared constants, arctangent table and cell data types for the radar
// measurement unit.
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 24;
    localparam int ANG_BITS      = 30;
    localparam int ANG_SH        = ANG_BITS - FRAC_BITS;
    localparam int SQRT_CELLS    = 32;
    localparam int DIV_CELLS     = 33;

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [32:0]        RATE_MAX    = 33'd3037000500;

    // atan(2^-i) in Q30, rounded to nearest
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [34:0] z;
        logic               spec;   // axis case: z already final
    } cordic_t;

    typedef struct packed {
        logic [63:0] s;      // radicand bits not yet consumed
        logic [31:0] q;      // partial root
        logic [33:0] rem;    // partial remainder
        logic [63:0] mag;    // dot product magnitude
        logic        neg;    // dot product sign
    } sqrt_t;

    typedef struct packed {
        logic [32:0] num;    // dividend bits not yet consumed
        logic [31:0] rem;
        logic [32:0] q;
        logic [31:0] r;      // divisor, also the range result
        logic        neg;
        logic        zero;
        logic        sat;
    } div_t;

    function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
        atan_q30 = signed'({5'b0, ATAN_TAB[idx]});
    endfunction

endpackage

// ===== hw/rtl/crm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// crm_sqrt_cell
// One restoring square-root step: resolve one root bit per cell.
// ----------------------------------------------------------------------------
module crm_sqrt_cell
    import crm_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t cin,
    output sqrt_t cout
);

    sqrt_t       cell_reg;
    sqrt_t       cell_next;
    logic [35:0] t;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        t         = {cin.rem, cin.s[63:62]};
        trial     = {2'b00, cin.q, 2'b01};
        diff      = t - trial;
        ge        = (t >= trial);
        cell_next = cin;
        cell_next.s   = {cin.s[61:0], 2'b00};
        cell_next.q   = {cin.q[30:0], ge};
        cell_next.rem = ge ? diff[33:0] : t[33:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;

endmodule

// ===== hw/rtl/crm_div_cell.sv =====
// ----------------------------------------------------------------------------
// crm_div_cell
// One restoring division step: resolve one quotient bit per cell.
// ----------------------------------------------------------------------------
module crm_div_cell
    import crm_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t cin,
    output div_t cout
);

    div_t        cell_reg;
    div_t        cell_next;
    logic [32:0] t;
    logic [32:0] dvs;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        t         = {cin.rem, cin.num[32]};
        dvs       = {1'b0, cin.r};
        diff      = t - dvs;
        ge        = (t >= dvs);
        cell_next = cin;
        cell_next.num = {cin.num[31:0], 1'b0};
        cell_next.rem = ge ? diff[31:0] : t[31:0];
        cell_next.q   = {cin.q[31:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;

endmodule

// ===== hw/rtl/crm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// crm_cordic_cell
// One vectoring CORDIC micro-rotation; hold the vector on axis cases.
// ----------------------------------------------------------------------------
module crm_cordic_cell
    import crm_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [4:0] idx,
    input  cordic_t    cin,
    output cordic_t    cout
);

    cordic_t            cell_reg;
    cordic_t            cell_next;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [34:0] da;

    always_comb
    begin
        dx        = cin.y >>> idx;
        dy        = cin.x >>> idx;
        da        = atan_q30(idx);
        cell_next = cin;
        if (!cin.spec)
        begin
            if (!cin.y[63])
            begin
                cell_next.x = cin.x + dx;
                cell_next.y = cin.y - dy;
                cell_next.z = cin.z + da;
            end
            else
            begin
                cell_next.x = cin.x - dx;
                cell_next.y = cin.y + dy;
                cell_next.z = cin.z - da;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;

endmodule

// ===== hw/rtl/cartesian_to_radar_measurement_unit.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_radar_measurement_unit
// Convert a 2-D position/velocity state into range, bearing and range rate.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | pos_x, pos_y, vel_x, vel_y
//  out     | out_valid / out_stall | range, bearing, range_rate, zero_range
//
//  One request is accepted per cycle while in_stall is low; every request yields one result.
//  The pipeline runs through the input register, multiply, sum, 32 square-root cells,
//  rounding, dividend setup, 33 divider cells and the output register. The bearing
//  CORDIC (CORDIC_STAGES cells) runs beside the square root and waits in a
//  delay line. The pipeline advances as a whole while the skid register is
//  empty; in_stall rises only once the output is held and the skid is full.
//  Reset clears the valid bits, the output valid bit and the skid flag.
//
module cartesian_to_radar_measurement_unit
    import crm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [31:0] range,
    output logic signed [18:0] bearing,
    output logic signed [32:0] range_rate,
    output logic               zero_range
);

    localparam int NSTG = 3 + SQRT_CELLS + 2 + DIV_CELLS;
    localparam int BDLY = NSTG - 2 - CORDIC_STAGES;

    logic en;
    logic vld_reg [NSTG];

    // stage 0: input register
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;

    // stage 1: magnitudes, products, CORDIC setup
    logic [31:0] ax, ay, avx, avy;
    logic [63:0] sqx_reg, sqy_reg, m1_reg, m2_reg;
    logic        n1_reg, n2_reg;
    cordic_t     cor_next;
    cordic_t     cor_reg;
    logic signed [63:0] xw, yw;

    // stage 2: sum of squares and signed dot product
    logic        n1a, n2a;
    sqrt_t       sq_next;
    sqrt_t       sq_reg;

    // rounding and dividend stages
    logic [31:0] r_next, r_reg;
    logic [63:0] mag_reg;
    logic        neg_reg;
    logic [63:0] num;
    div_t        dv_next;
    div_t        dv_reg;

    // cell chains
    cordic_t cor_w [CORDIC_STAGES+1];
    sqrt_t   sq_w  [SQRT_CELLS+1];
    div_t    dv_w  [DIV_CELLS+1];

    // bearing rounding and delay line
    logic signed [34:0] zc;
    logic signed [35:0] zr;
    logic signed [35:0] bn;
    logic        [18:0] b_dly_reg [BDLY];

    // final result
    div_t               dl;
    logic        [32:0] qs;
    logic signed [32:0] rate;

    // output register and skid
    logic               out_vld_reg, skid_vld_reg;
    logic        [31:0] out_r_reg, skid_r_reg;
    logic        [18:0] out_b_reg, skid_b_reg;
    logic        [32:0] out_q_reg, skid_q_reg;
    logic               out_z_reg, skid_z_reg;

    // advance the whole pipe while the skid slot is free
    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            vx_reg <= vel_x;
            vy_reg <= vel_y;
        end
    end

    // stage 1: absolute values feed unsigned multipliers; sign tracked apart
    always_comb
    begin
        ax  = px_reg[31] ? 32'(-px_reg) : px_reg;
        ay  = py_reg[31] ? 32'(-py_reg) : py_reg;
        avx = vx_reg[31] ? 32'(-vx_reg) : vx_reg;
        avy = vy_reg[31] ? 32'(-vy_reg) : vy_reg;

        // CORDIC setup: axis cases resolve at once, left half plane
        // is folded into the right by a half turn
        xw       = 64'(px_reg) <<< ANG_BITS;
        yw       = 64'(py_reg) <<< ANG_BITS;
        cor_next = '0;
        if (py_reg == 32'sd0)
        begin
            cor_next.spec = 1'b1;
            cor_next.z    = px_reg[31] ? PI_Q30 : 35'sd0;
        end
        else if (px_reg == 32'sd0)
        begin
            cor_next.spec = 1'b1;
            cor_next.z    = py_reg[31] ? -HALF_PI_Q30 : HALF_PI_Q30;
        end
        else if (px_reg[31])
        begin
            cor_next.x = -xw;
            cor_next.y = -yw;
            cor_next.z = py_reg[31] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            cor_next.x = xw;
            cor_next.y = yw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= 64'(ax) * 64'(ax);
            sqy_reg <= 64'(ay) * 64'(ay);
            m1_reg  <= 64'(ax) * 64'(avx);
            m2_reg  <= 64'(ay) * 64'(avy);
            n1_reg  <= px_reg[31] ^ vx_reg[31];
            n2_reg  <= py_reg[31] ^ vy_reg[31];
            cor_reg <= cor_next;
        end
    end

    // stage 2: a zero product takes the other term's sign
    always_comb
    begin
        n1a     = (m1_reg == 64'd0) ? n2_reg : n1_reg;
        n2a     = (m2_reg == 64'd0) ? n1a : n2_reg;
        sq_next = '0;
        sq_next.s = sqx_reg + sqy_reg;
        if (n1a == n2a)
        begin
            sq_next.mag = m1_reg + m2_reg;
            sq_next.neg = n1a;
        end
        else if (m1_reg >= m2_reg)
        begin
            sq_next.mag = m1_reg - m2_reg;
            sq_next.neg = n1a;
        end
        else
        begin
            sq_next.mag = m2_reg - m1_reg;
            sq_next.neg = n2a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

    // square-root chain: one root bit per cell
    assign sq_w[0] = sq_reg;
    for (genvar j = 0; j < SQRT_CELLS; j++)
    begin : g_sqrt
        crm_sqrt_cell u_cell (
            .clk  (clk),
            .en   (en),
            .cin  (sq_w[j]),
            .cout (sq_w[j+1])
        );
    end

    // round the root: bump when the remainder exceeds the floor root
    assign r_next = sq_w[SQRT_CELLS].q
                  + 32'(sq_w[SQRT_CELLS].rem > {2'b00, sq_w[SQRT_CELLS].q});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            mag_reg <= sq_w[SQRT_CELLS].mag;
            neg_reg <= sq_w[SQRT_CELLS].neg;
        end
    end

    // dividend with half-divisor rounding; quotients of 2^33 and up saturate
    always_comb
    begin
        num          = mag_reg + {33'd0, r_reg[31:1]};
        dv_next      = '0;
        dv_next.num  = num[32:0];
        dv_next.rem  = {1'b0, num[63:33]};
        dv_next.r    = r_reg;
        dv_next.neg  = neg_reg;
        dv_next.zero = (r_reg == 32'd0);
        dv_next.sat  = ({1'b0, num[63:33]} >= r_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= dv_next;
        end
    end

    // divider chain: one quotient bit per cell
    assign dv_w[0] = dv_reg;
    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        crm_div_cell u_cell (
            .clk  (clk),
            .en   (en),
            .cin  (dv_w[j]),
            .cout (dv_w[j+1])
        );
    end

    // bearing CORDIC chain
    assign cor_w[0] = cor_reg;
    for (genvar j = 0; j < CORDIC_STAGES; j++)
    begin : g_cordic
        crm_cordic_cell u_cell (
            .clk  (clk),
            .en   (en),
            .idx  (5'(j)),
            .cin  (cor_w[j]),
            .cout (cor_w[j+1])
        );
    end

    // clamp to [-pi, pi], round half up to the output fraction
    always_comb
    begin
        zc = cor_w[CORDIC_STAGES].z;
        if (zc > PI_Q30)
        begin
            zc = PI_Q30;
        end
        else if (zc < -PI_Q30)
        begin
            zc = -PI_Q30;
        end
        zr = 36'(zc) + (36'sd1 <<< (ANG_SH - 1));
        bn = zr >>> ANG_SH;
    end

    // hold the bearing until the divider catches up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dly_reg[0] <= bn[18:0];
            for (int i = 1; i < BDLY; i++)
            begin
                b_dly_reg[i] <= b_dly_reg[i-1];
            end
        end
    end

    // final: saturate, apply sign, force zero on zero range
    always_comb
    begin
        dl = dv_w[DIV_CELLS];
        qs = (dl.sat || (dl.q > RATE_MAX)) ? RATE_MAX : dl.q;
        if (dl.zero)
        begin
            rate = 33'sd0;
        end
        else if (dl.neg)
        begin
            rate = -signed'(qs);
        end
        else
        begin
            rate = signed'(qs);
        end
    end

    // output register with one-deep skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || !out_stall)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= vld_reg[NSTG-1];
            end
        end
        else if (vld_reg[NSTG-1] && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || !out_stall)
        begin
            if (skid_vld_reg)
            begin
                out_r_reg <= skid_r_reg;
                out_b_reg <= skid_b_reg;
                out_q_reg <= skid_q_reg;
                out_z_reg <= skid_z_reg;
            end
            else
            begin
                out_r_reg <= dl.r;
                out_b_reg <= b_dly_reg[BDLY-1];
                out_q_reg <= rate;
                out_z_reg <= dl.zero;
            end
        end
        else if (en)
        begin
            skid_r_reg <= dl.r;
            skid_b_reg <= b_dly_reg[BDLY-1];
            skid_q_reg <= rate;
            skid_z_reg <= dl.zero;
        end
    end

    assign out_valid  = out_vld_reg;
    assign range      = out_r_reg;
    assign bearing    = signed'(out_b_reg);
    assign range_rate = signed'(out_q_reg);
    assign zero_range = out_z_reg;

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while the output is empty");

    a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_stall))
        else $error("skid filled without an output stall");

    a_zero_range : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_z_reg) |-> (out_r_reg == 32'd0 && out_q_reg == 33'd0))
        else $error("zero range flag with nonzero range or rate");
`endif

endmodule
